/* hw/rtl/mrc_pkg.sv */
// mrc_pkg: register map and shared types for the magnetization rate cell.
// No dependencies; imported by the top level.
package mrc_pkg;

	localparam int CFG_IDX_BITS = 3;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_GYRO      = 3'd0;
	localparam cfg_idx_t REG_BETA      = 3'd1;
	localparam cfg_idx_t REG_PREC      = 3'd2;
	localparam cfg_idx_t REG_REDUCED   = 3'd3;
	localparam cfg_idx_t REG_NORM_GAIN = 3'd4;

	// mode bits held in the register file
	typedef struct packed {
		logic prec;
		logic reduced;
	} mode_t;

endpackage

/* hw/rtl/mrc_mul.sv */
// mrc_mul: two-stage signed fixed-point multiply, round half away from zero, saturate.
// No package dependency; instantiated by the top level.
module mrc_mul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] y,
	output logic                clip
);
	localparam int W2 = 2 * W;
	localparam int QW = W2 - F;
	localparam logic [QW-1:0] LIM = QW'({(W-1){1'b1}});
	localparam logic [W2-1:0] HALF = W2'(1) << (F - 1);

	logic signed [W2-1:0] prod_s1;
	logic                 neg;
	logic [W2-1:0]        mag;
	logic [W2-1:0]        rnd;
	logic [QW-1:0]        q;
	logic [QW-1:0]        lim;
	logic                 ovf;
	logic [QW-1:0]        qs;

	always_ff @(posedge clk) begin
		prod_s1 <= W2'(a) * W2'(b);
	end

	always_comb begin
		neg = prod_s1[W2-1];
		mag = neg ? W2'(-prod_s1) : W2'(prod_s1);
		rnd = mag + HALF;
		q   = rnd[W2-1:F];
		lim = LIM + QW'(neg);
		ovf = q > lim;
		qs  = ovf ? lim : q;
	end

	always_ff @(posedge clk) begin
		y    <= neg ? -$signed(qs[W-1:0]) : $signed(qs[W-1:0]);
		clip <= ovf;
	end

endmodule

/* hw/rtl/mrc_sqrt.sv */
// mrc_sqrt: pipelined integer square root, one result bit per stage (W+1 stages).
// No package dependency; instantiated by the top level.
module mrc_sqrt #(
	parameter int W = 32
) (
	input  logic            clk,
	input  logic [2*W-1:0]  rad,
	output logic [W:0]      root
);
	localparam int RW = 2 * W + 3;

	logic [RW-1:0] rem_s [1:W+1];
	logic [W:0]    res_s [1:W+1];

	for (genvar s = 0; s <= W; s++) begin : g_stage
		localparam int B = W - s;
		logic [RW-1:0] rem_in;
		logic [W:0]    res_in;
		logic [RW-1:0] trial;
		logic          take;

		if (s == 0) begin : g_first
			assign rem_in = RW'(rad);
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[s];
			assign res_in = res_s[s];
		end

		// (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
		assign trial = (RW'(res_in) << (B + 1)) | (RW'(1) << (2 * B));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			rem_s[s+1] <= take ? rem_in - trial : rem_in;
			res_s[s+1] <= res_in | ((W+1)'(take) << B);
		end
	end

	assign root = res_s[W+1];

endmodule

/* hw/rtl/magnetization_rate_cell_top.sv */
// magnetization_rate_cell_top: per-cell magnetization rate, fully pipelined.
// done is registered together with the output registers, so the result is taken while done is high.
// Throughput: one cell per clock; busy stays low, a new cell may start every cycle.
// Depth is set mostly by the rate-magnitude square root, one result bit per stage.
// Reset: valid pipeline cleared, configuration back to defaults; receiver cannot stall.
// cfg_ready is low while start is high or any cell is in flight.
// Depends on mrc_pkg, mrc_mul and mrc_sqrt.
module magnetization_rate_cell_top
	import mrc_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  cfg_idx_t                    cfg_index,
	input  logic [WORD_BITS-1:0]        cfg_data,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_BITS-1:0] mag_x,
	input  logic signed [WORD_BITS-1:0] mag_y,
	input  logic signed [WORD_BITS-1:0] mag_z,
	input  logic signed [WORD_BITS-1:0] field_x,
	input  logic signed [WORD_BITS-1:0] field_y,
	input  logic signed [WORD_BITS-1:0] field_z,
	input  logic signed [WORD_BITS-1:0] lap_x,
	input  logic signed [WORD_BITS-1:0] lap_y,
	input  logic signed [WORD_BITS-1:0] lap_z,
	input  logic [WORD_BITS-2:0]        damping,
	input  logic                        pinned,
	input  logic                        last_cell,
	// result side
	output logic                        done,
	output logic signed [WORD_BITS-1:0] rate_x,
	output logic signed [WORD_BITS-1:0] rate_y,
	output logic signed [WORD_BITS-1:0] rate_z,
	output logic                        saturated,
	output logic                        last_out
);
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;

	// stage map (register outputs)
	localparam int ST_SQ   = 16 + W;   // square root done
	localparam int ST_GAIN = 17 + W;   // norm gain c selected
	localparam int ST_K    = 19 + W;   // k = c*(1-mm)
	localparam int ST_KM   = 21 + W;   // k*m
	localparam int LAST    = 22 + W;   // output registers

	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-2:0]        GYRO_RST = (W-1)'(1) << F;
	localparam logic [W-1:0]        FNG_RST  = -(W'(1) << F);
	localparam logic                ONE_CLIP = (F > W - 2);
	localparam logic signed [W-1:0] ONE      = ONE_CLIP ? WMAX : $signed(W'(1) << F);

	// saturating add/subtract: {clip, value}
	function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b, input logic sub);
		logic signed [W:0] s;
		logic [W:0]        r;
		s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
		if (s[W] != s[W-1]) begin
			r = {1'b1, s[W] ? WMIN : WMAX};
		end else begin
			r = {1'b0, s[W-1:0]};
		end
		return r;
	endfunction

	//------------------------------------------------------------------
	// Configuration registers; written only while the pipe is empty.
	//------------------------------------------------------------------
	logic [W-2:0]        gyro_q;
	logic signed [W-1:0] beta_q;
	logic signed [W-1:0] fng_q;
	mode_t               mode_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_q         <= GYRO_RST;
			beta_q         <= '0;
			fng_q          <= FNG_RST;
			mode_q.prec    <= 1'b1;
			mode_q.reduced <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GYRO:      gyro_q         <= cfg_data[W-2:0];
				REG_BETA:      beta_q         <= cfg_data;
				REG_PREC:      mode_q.prec    <= cfg_data[0];
				REG_REDUCED:   mode_q.reduced <= cfg_data[0];
				REG_NORM_GAIN: fng_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [W-1:0] gam;
	logic signed [W-1:0] neg_gam;
	assign gam     = $signed({1'b0, gyro_q});
	assign neg_gam = -gam;

	//------------------------------------------------------------------
	// Control pipe: valid, pin, last and clip flags travel with the cell.
	//------------------------------------------------------------------
	logic vld_s  [1:LAST];
	logic pin_s  [1:LAST-1];
	logic lst_s  [1:LAST-1];
	logic flp_s  [1:LAST-1];   // clips seen, plain form
	logic flr_s  [1:LAST-1];   // clips seen, reduced form
	logic clip_p [1:LAST-1];
	logic clip_r [1:LAST-1];
	logic in_flight;

	// config is read up to the output registers; hold writes until those are loaded
	always_comb begin
		in_flight = 1'b0;
		for (int n = 1; n <= LAST - 1; n++) in_flight = in_flight | vld_s[n];
	end

	assign cfg_ready = !start && !in_flight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= LAST; n++) vld_s[n] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int n = 2; n <= LAST; n++) vld_s[n] <= vld_s[n-1];
		end
	end

	always_ff @(posedge clk) begin
		pin_s[1] <= pinned;
		lst_s[1] <= last_cell;
		flp_s[1] <= 1'b0;
		flr_s[1] <= 1'b0;
		for (int n = 2; n <= LAST - 1; n++) begin
			pin_s[n] <= pin_s[n-1];
			lst_s[n] <= lst_s[n-1];
			flp_s[n] <= flp_s[n-1] | clip_p[n-1];
			flr_s[n] <= flr_s[n-1] | clip_r[n-1];
		end
	end

	//------------------------------------------------------------------
	// s1: input registers
	//------------------------------------------------------------------
	logic [2:0][W-1:0]   m_s [1:ST_K];
	logic signed [W-1:0] h_s1 [3];
	logic signed [W-1:0] l_s1 [3];
	logic signed [W-1:0] a_s1;

	always_ff @(posedge clk) begin
		m_s[1] <= {mag_z, mag_y, mag_x};
		h_s1[0] <= field_x;
		h_s1[1] <= field_y;
		h_s1[2] <= field_z;
		l_s1[0] <= lap_x;
		l_s1[1] <= lap_y;
		l_s1[2] <= lap_z;
		a_s1    <= $signed({1'b0, damping});
		for (int n = 2; n <= ST_K; n++) m_s[n] <= m_s[n-1];
	end

	//------------------------------------------------------------------
	// s1 -> s3: cross-product terms, alpha*h, beta*l, m_i^2
	//------------------------------------------------------------------
	logic signed [W-1:0] cra_s3 [3], crb_s3 [3], ah_s3 [3], bl_s3 [3], sq_s3 [3];
	logic [2:0]          cra_c, crb_c, ah_c, bl_c, sq_c;

	for (genvar i = 0; i < 3; i++) begin : g_mul_a
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		mrc_mul #(.W(W), .F(F)) u_cra (.clk(clk), .a($signed(m_s[1][J])), .b(h_s1[K]),
			.y(cra_s3[i]), .clip(cra_c[i]));
		mrc_mul #(.W(W), .F(F)) u_crb (.clk(clk), .a($signed(m_s[1][K])), .b(h_s1[J]),
			.y(crb_s3[i]), .clip(crb_c[i]));
		mrc_mul #(.W(W), .F(F)) u_ah (.clk(clk), .a(a_s1), .b(h_s1[i]),
			.y(ah_s3[i]), .clip(ah_c[i]));
		mrc_mul #(.W(W), .F(F)) u_bl (.clk(clk), .a(beta_q), .b(l_s1[i]),
			.y(bl_s3[i]), .clip(bl_c[i]));
		mrc_mul #(.W(W), .F(F)) u_sq (.clk(clk), .a($signed(m_s[1][i])),
			.b($signed(m_s[1][i])), .y(sq_s3[i]), .clip(sq_c[i]));
	end

	//------------------------------------------------------------------
	// s4: m x h, d = alpha*h - beta*l, mm = m.m
	//------------------------------------------------------------------
	logic signed [W-1:0] x_s4 [3], d_s4 [3], mm_s4;
	logic [2:0]          x_c_s4, d_c_s4;
	logic                mm_c_s4;
	logic [W:0]          xs [3], ds [3], mm1, mm2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xs[i] = sat_add(cra_s3[i], crb_s3[i], 1'b1);
			ds[i] = sat_add(ah_s3[i], bl_s3[i], 1'b1);
		end
		mm1 = sat_add(sq_s3[0], sq_s3[1], 1'b0);
		mm2 = sat_add(mm1[W-1:0], sq_s3[2], 1'b0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			x_s4[i]   <= xs[i][W-1:0];
			x_c_s4[i] <= xs[i][W];
			d_s4[i]   <= ds[i][W-1:0];
			d_c_s4[i] <= ds[i][W];
		end
		mm_s4   <= mm2[W-1:0];
		mm_c_s4 <= mm1[W] | mm2[W];
	end

	//------------------------------------------------------------------
	// s4 -> s6: precession, gamma*d, m_i*d_i, mm*d_i ; s5: 1 - mm
	//------------------------------------------------------------------
	logic signed [W-1:0] pr_s6 [3], gd_s6 [3], md_s6 [3], mmd_s6 [3];
	logic [2:0]          pr_c, gd_c, md_c, mmd_c;

	for (genvar i = 0; i < 3; i++) begin : g_mul_b
		mrc_mul #(.W(W), .F(F)) u_pr (.clk(clk), .a(neg_gam), .b(x_s4[i]),
			.y(pr_s6[i]), .clip(pr_c[i]));
		mrc_mul #(.W(W), .F(F)) u_gd (.clk(clk), .a(gam), .b(d_s4[i]),
			.y(gd_s6[i]), .clip(gd_c[i]));
		mrc_mul #(.W(W), .F(F)) u_md (.clk(clk), .a($signed(m_s[4][i])), .b(d_s4[i]),
			.y(md_s6[i]), .clip(md_c[i]));
		mrc_mul #(.W(W), .F(F)) u_mmd (.clk(clk), .a(mm_s4), .b(d_s4[i]),
			.y(mmd_s6[i]), .clip(mmd_c[i]));
	end

	logic signed [W-1:0] om_s [5:ST_GAIN];
	logic                om_c_s5;
	logic [W:0]          oms;

	assign oms = sat_add(ONE, mm_s4, 1'b1);

	always_ff @(posedge clk) begin
		om_s[5] <= oms[W-1:0];
		om_c_s5 <= oms[W];
		for (int n = 6; n <= ST_GAIN; n++) om_s[n] <= om_s[n-1];
	end

	//------------------------------------------------------------------
	// s7: plain rate, mh = m.d ; precession and mm*d delayed
	//------------------------------------------------------------------
	logic signed [W-1:0] p6 [3];
	logic [W:0]          rps [3], mh1, mh2;
	logic [2:0][W-1:0]   p_s   [7:12];
	logic [2:0][W-1:0]   mmd_s [7:9];
	logic [2:0][W-1:0]   rp_s  [7:ST_KM];
	logic [2:0]          rp_c_s7;
	logic signed [W-1:0] mh_s7;
	logic                mh_c_s7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p6[i]  = mode_q.prec ? pr_s6[i] : '0;
			rps[i] = sat_add(p6[i], gd_s6[i], 1'b0);
		end
		mh1 = sat_add(md_s6[0], md_s6[1], 1'b0);
		mh2 = sat_add(mh1[W-1:0], md_s6[2], 1'b0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s[7][i]   <= p6[i];
			mmd_s[7][i] <= mmd_s6[i];
			rp_s[7][i]  <= rps[i][W-1:0];
			rp_c_s7[i]  <= rps[i][W];
		end
		mh_s7   <= mh2[W-1:0];
		mh_c_s7 <= mh1[W] | mh2[W];
		for (int n = 8; n <= 12; n++) p_s[n] <= p_s[n-1];
		for (int n = 8; n <= 9; n++) mmd_s[n] <= mmd_s[n-1];
		for (int n = 8; n <= ST_KM; n++) rp_s[n] <= rp_s[n-1];
	end

	//------------------------------------------------------------------
	// s7 -> s9: mh*m ; s10: e = mm*d - mh*m ; s10 -> s12: gamma*e
	//------------------------------------------------------------------
	logic signed [W-1:0] mhm_s9 [3], e_s10 [3], ge_s12 [3];
	logic [2:0]          mhm_c, e_c_s10, ge_c;
	logic [W:0]          es [3];

	for (genvar i = 0; i < 3; i++) begin : g_mul_c
		mrc_mul #(.W(W), .F(F)) u_mhm (.clk(clk), .a(mh_s7), .b($signed(m_s[7][i])),
			.y(mhm_s9[i]), .clip(mhm_c[i]));
		mrc_mul #(.W(W), .F(F)) u_ge (.clk(clk), .a(gam), .b(e_s10[i]),
			.y(ge_s12[i]), .clip(ge_c[i]));
	end

	always_comb begin
		for (int i = 0; i < 3; i++) es[i] = sat_add($signed(mmd_s[9][i]), mhm_s9[i], 1'b1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_s10[i]   <= es[i][W-1:0];
			e_c_s10[i] <= es[i][W];
		end
	end

	//------------------------------------------------------------------
	// s13: reduced-form rate before norm correction
	//------------------------------------------------------------------
	logic [2:0][W-1:0] r_s [13:ST_KM];
	logic [2:0]        r_c_s13;
	logic [W:0]        rs [3];

	always_comb begin
		for (int i = 0; i < 3; i++) rs[i] = sat_add($signed(p_s[12][i]), ge_s12[i], 1'b0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s[13][i] <= rs[i][W-1:0];
			r_c_s13[i] <= rs[i][W];
		end
		for (int n = 14; n <= ST_KM; n++) r_s[n] <= r_s[n-1];
	end

	//------------------------------------------------------------------
	// s14..ST_GAIN: |r| = floor(sqrt(sum r_i^2)), c = 6*|r| or fixed gain
	//------------------------------------------------------------------
	logic [W-1:0]        rabs [3];
	logic [2*W-1:0]      rsq_s14 [3];
	logic [2*W-1:0]      ssum_s15;
	logic [W:0]          root;
	logic [W+3:0]        g6;
	logic                g6_ovf;
	logic signed [W-1:0] c_sg;
	logic                c_c_sg;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rabs[i] = r_s[13][i][W-1] ? W'(-$signed(r_s[13][i])) : r_s[13][i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) rsq_s14[i] <= (2*W)'(rabs[i]) * (2*W)'(rabs[i]);
		ssum_s15 <= rsq_s14[0] + rsq_s14[1] + rsq_s14[2];
	end

	mrc_sqrt #(.W(W)) u_sqrt (.clk(clk), .rad(ssum_s15), .root(root));

	assign g6     = ((W+4)'(root) << 2) + ((W+4)'(root) << 1);
	assign g6_ovf = g6 > (W+4)'(WMAX);

	always_ff @(posedge clk) begin
		if (fng_q[W-1]) begin
			c_sg <= g6_ovf ? WMAX : $signed(g6[W-1:0]);
		end else begin
			c_sg <= fng_q;
		end
		c_c_sg <= g6_ovf & fng_q[W-1];
	end

	//------------------------------------------------------------------
	// k = c*(1-mm), then k*m, then final add
	//------------------------------------------------------------------
	logic signed [W-1:0] k_sk;
	logic                k_c;
	logic signed [W-1:0] km_skm [3];
	logic [2:0]          km_c;
	logic [W:0]          fs [3];

	mrc_mul #(.W(W), .F(F)) u_k (.clk(clk), .a(c_sg), .b(om_s[ST_GAIN]),
		.y(k_sk), .clip(k_c));

	for (genvar i = 0; i < 3; i++) begin : g_mul_km
		mrc_mul #(.W(W), .F(F)) u_km (.clk(clk), .a(k_sk), .b($signed(m_s[ST_K][i])),
			.y(km_skm[i]), .clip(km_c[i]));
	end

	always_comb begin
		for (int i = 0; i < 3; i++) fs[i] = sat_add($signed(r_s[ST_KM][i]), km_skm[i], 1'b0);
	end

	//------------------------------------------------------------------
	// clip bookkeeping, per stage where each flag is registered
	//------------------------------------------------------------------
	always_comb begin
		for (int n = 1; n <= LAST - 1; n++) begin
			clip_p[n] = 1'b0;
			clip_r[n] = 1'b0;
		end
		// shared terms
		clip_p[3] = (mode_q.prec & (|cra_c | |crb_c)) | |ah_c | |bl_c;
		clip_r[3] = clip_p[3] | |sq_c;
		clip_p[4] = (mode_q.prec & |x_c_s4) | |d_c_s4;
		clip_r[4] = clip_p[4] | mm_c_s4;
		clip_r[5] = om_c_s5 | ONE_CLIP;
		clip_p[6] = (mode_q.prec & |pr_c) | |gd_c;
		clip_r[6] = (mode_q.prec & |pr_c) | |md_c | |mmd_c;
		clip_p[7] = |rp_c_s7;
		clip_r[7] = mh_c_s7;
		clip_r[9]  = |mhm_c;
		clip_r[10] = |e_c_s10;
		clip_r[12] = |ge_c;
		clip_r[13] = |r_c_s13;
		clip_r[ST_GAIN] = c_c_sg;
		clip_r[ST_K]    = k_c;
		clip_r[ST_KM]   = |km_c;
	end

	//------------------------------------------------------------------
	// output registers
	//------------------------------------------------------------------
	logic sat_red, sat_plain;

	assign sat_red   = flr_s[ST_KM] | clip_r[ST_KM] | fs[0][W] | fs[1][W] | fs[2][W];
	assign sat_plain = flp_s[ST_KM] | clip_p[ST_KM];

	always_ff @(posedge clk) begin
		last_out <= lst_s[ST_KM];
		if (pin_s[ST_KM]) begin
			rate_x    <= '0;
			rate_y    <= '0;
			rate_z    <= '0;
			saturated <= 1'b0;
		end else if (mode_q.reduced) begin
			rate_x    <= fs[0][W-1:0];
			rate_y    <= fs[1][W-1:0];
			rate_z    <= fs[2][W-1:0];
			saturated <= sat_red;
		end else begin
			rate_x    <= rp_s[ST_KM][0];
			rate_y    <= rp_s[ST_KM][1];
			rate_z    <= rp_s[ST_KM][2];
			saturated <= sat_plain;
		end
	end

	assign done = vld_s[LAST];

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LAST) done)
		else $error("accepted transaction did not complete at fixed latency");

	a_pinned_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_KM] && pin_s[ST_KM] |=> done && rate_x == 0 && rate_y == 0 &&
		rate_z == 0 && !saturated)
		else $error("pinned cell produced a nonzero rate");

	a_done_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s[ST_KM]))
		else $error("result strobe without a transaction in flight");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !start && !vld_s[1])
		else $error("configuration written with a transaction in flight");

endmodule

/* sim/mrc_rate_checker.sv */
// mrc_rate_checker: watches the cell and config channels, predicts each cell's rate
// and compares it with the strobed result. Depends on mrc_pkg.
`timescale 1ns / 100ps
module mrc_rate_checker
	import mrc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  cfg_idx_t           cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] mag_x, mag_y, mag_z,
	input  logic signed [31:0] field_x, field_y, field_z,
	input  logic signed [31:0] lap_x, lap_y, lap_z,
	input  logic [30:0]        damping,
	input  logic               pinned,
	input  logic               last_cell,
	input  logic               done,
	input  logic signed [31:0] rate_x, rate_y, rate_z,
	input  logic               saturated,
	input  logic               last_out,
	output int                 fail_count,
	output int                 pending_rates
);

	typedef struct packed {
		logic signed [31:0] rx, ry, rz;
		logic               sat;
		logic               last;
	} cell_rate_t;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	cell_rate_t rate_q[$];
	logic [30:0] gamma_r;
	logic signed [31:0] beta_r, gain_r;
	mode_t mode_r;
	bit clipped;

	assign pending_rates = rate_q.size();

	function automatic longint clip_word(input longint v);
		if (v > WMAX) begin
			clipped = 1;
			return WMAX;
		end
		if (v < WMIN) begin
			clipped = 1;
			return WMIN;
		end
		return v;
	endfunction

	// exact product, round half away from zero, then saturate
	function automatic longint fx_mul(input longint a, input longint b);
		logic signed [127:0] p;
		logic [127:0] mag;
		logic neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p[127];
		mag = neg ? -p : p;
		mag = (mag + 128'(32768)) >> 16;
		if (mag > 128'(WMAX) + (neg ? 1 : 0)) begin
			clipped = 1;
			mag = 128'(WMAX) + (neg ? 1 : 0);
		end
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	function automatic longint norm_gain_from(input longint r[3]);
		logic [127:0] s, t;
		logic [63:0] root;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += 128'(r[i] < 0 ? -r[i] : r[i]) * 128'(r[i] < 0 ? -r[i] : r[i]);
		root = 0;
		for (int b = 32; b >= 0; b--) begin
			t = 128'(root | (64'd1 << b));
			if (t * t <= s)
				root = t[63:0];
		end
		root = root * 6;
		if (root > 64'(WMAX)) begin
			clipped = 1;
			return WMAX;
		end
		return longint'(root);
	endfunction

	function automatic cell_rate_t predict_rate();
		cell_rate_t o;
		longint m[3], h[3], l[3], d[3], p[3], r[3];
		longint g, a, mm, md, c, k;
		clipped = 0;
		o = '0;
		o.last = last_cell;
		if (pinned)
			return o;
		m = '{mag_x, mag_y, mag_z};
		h = '{field_x, field_y, field_z};
		l = '{lap_x, lap_y, lap_z};
		g = longint'(gamma_r);
		a = longint'(damping);
		for (int i = 0; i < 3; i++) begin
			int j, n;
			j = (i + 1) % 3;
			n = (i + 2) % 3;
			p[i] = 0;
			if (mode_r.prec)
				p[i] = fx_mul(-g, clip_word(fx_mul(m[j], h[n]) - fx_mul(m[n], h[j])));
			d[i] = clip_word(fx_mul(a, h[i]) - fx_mul(longint'(beta_r), l[i]));
		end
		if (!mode_r.reduced) begin
			for (int i = 0; i < 3; i++)
				r[i] = clip_word(p[i] + fx_mul(g, d[i]));
		end else begin
			mm = 0;
			md = 0;
			for (int i = 0; i < 3; i++) begin
				mm = clip_word(mm + fx_mul(m[i], m[i]));
				md = clip_word(md + fx_mul(m[i], d[i]));
			end
			for (int i = 0; i < 3; i++)
				r[i] = clip_word(p[i] + fx_mul(g, clip_word(fx_mul(mm, d[i]) - fx_mul(md, m[i]))));
			c = longint'(gain_r);
			if (c < 0)
				c = norm_gain_from(r);
			k = fx_mul(c, clip_word(65536 - mm));
			for (int i = 0; i < 3; i++)
				r[i] = clip_word(r[i] + fx_mul(k, m[i]));
		end
		o.rx = r[0][31:0];
		o.ry = r[1][31:0];
		o.rz = r[2][31:0];
		o.sat = clipped;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		cell_rate_t want;
		if (!arst_n) begin
			gamma_r <= 31'd65536;
			beta_r <= '0;
			mode_r <= '{prec: 1'b1, reduced: 1'b0};
			gain_r <= -32'sd65536;
			fail_count <= 0;
			rate_q.delete();
		end else begin
			if (done) begin
				if (rate_q.size() == 0) begin
					$error("rate result with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = rate_q.pop_front();
					if (want != {rate_x, rate_y, rate_z, saturated, last_out}) begin
						fail_count <= fail_count + 1;
						if (want.rx != rate_x)
							$error("rate_x exp %0d got %0d", want.rx, rate_x);
						if (want.ry != rate_y)
							$error("rate_y exp %0d got %0d", want.ry, rate_y);
						if (want.rz != rate_z)
							$error("rate_z exp %0d got %0d", want.rz, rate_z);
						if (want.sat != saturated)
							$error("saturated exp %0d got %0d", want.sat, saturated);
						if (want.last != last_out)
							$error("last_out exp %0d got %0d", want.last, last_out);
					end
				end
			end
			if (start && !busy)
				rate_q.push_back(predict_rate());
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GYRO:      gamma_r <= cfg_data[30:0];
					REG_BETA:      beta_r <= cfg_data;
					REG_PREC:      mode_r.prec <= cfg_data[0];
					REG_REDUCED:   mode_r.reduced <= cfg_data[0];
					REG_NORM_GAIN: gain_r <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* sim/tb_magnetization_rate_cell_top.sv */
// tb_magnetization_rate_cell_top: stimulus and verdict for the magnetization rate cell.
// Depends on mrc_pkg, magnetization_rate_cell_top and mrc_rate_checker.
`timescale 1ns / 100ps
module tb_magnetization_rate_cell_top;
	import mrc_pkg::*;

	localparam int WATCH_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;   // pipeline depth is 54

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	cfg_idx_t cfg_index;
	logic [31:0] cfg_data;
	logic start, busy, done;
	logic signed [31:0] mag_x, mag_y, mag_z, field_x, field_y, field_z;
	logic signed [31:0] lap_x, lap_y, lap_z, rate_x, rate_y, rate_z;
	logic [30:0] damping;
	logic pinned, last_cell, saturated, last_out;
	int fail_count, pending_rates;
	int idle_cycles;
	int gap_pct;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	magnetization_rate_cell_top DUT (.*);

	mrc_rate_checker u_checker (.*);

	// watchdog: counts cycles with no accepted transaction of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word(input int shape);
		// mix full-range words with values near unit magnitude so reduced mode
		// reaches its interesting region instead of saturating every time
		case (shape)
			0: return $urandom();
			1: return $signed($urandom_range(0, 131072)) - 65536;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 2097152)) - 1048576;
		endcase
	endfunction

	// write one register; only called with the pipeline drained
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_rates != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one cell transaction; start stays high across back-to-back cells
	task automatic send_cell(input logic [31:0] m[3], input logic [31:0] h[3],
			input logic [31:0] lp[3], input logic [30:0] damp, input logic pin,
			input logic last);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{mag_x, mag_y, mag_z} <= {m[0], m[1], m[2]};
		{field_x, field_y, field_z} <= {h[0], h[1], h[2]};
		{lap_x, lap_y, lap_z} <= {lp[0], lp[1], lp[2]};
		damping <= damp;
		pinned <= pin;
		last_cell <= last;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_random(input int count, input int shape_max);
		logic [31:0] m[3], h[3], lp[3];
		int s;
		for (int n = 0; n < count; n++) begin
			s = $urandom_range(0, shape_max);
			for (int i = 0; i < 3; i++) begin
				m[i] = rand_word(s);
				h[i] = rand_word($urandom_range(0, shape_max));
				lp[i] = rand_word($urandom_range(0, shape_max));
			end
			send_cell(m, h, lp, $urandom_range(0, 3) == 0 ? 31'($urandom()) :
				31'($urandom_range(0, 131072)), $urandom_range(0, 9) == 0,
				$urandom_range(0, 1));
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [31:0] g, input logic [31:0] b, input logic prec,
			input logic red, input logic [31:0] c);
		write_reg(REG_GYRO, g);
		write_reg(REG_BETA, b);
		write_reg(REG_PREC, {31'd0, prec});
		write_reg(REG_REDUCED, {31'd0, red});
		write_reg(REG_NORM_GAIN, c);
	endtask

	initial begin
		logic [31:0] zero3[3], unit_z[3], maxv[3], minv[3], hv[3];
		zero3 = '{0, 0, 0};
		unit_z = '{0, 0, 32'h10000};
		maxv = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		minv = '{32'h80000000, 32'h80000000, 32'h80000000};
		hv = '{32'h8000, 32'hffff0000, 32'h20000};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GYRO;
		cfg_data = '0;
		start = 1'b0;
		{mag_x, mag_y, mag_z, field_x, field_y, field_z} = '0;
		{lap_x, lap_y, lap_z} = '0;
		damping = '0;
		pinned = 1'b0;
		last_cell = 1'b0;
		idle_cycles = 0;
		gap_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cells under reset defaults: zero, unit, extremes, pinned
		send_cell(zero3, zero3, zero3, 0, 0, 0);
		send_cell(unit_z, hv, hv, 31'h10000, 0, 0);
		send_cell(maxv, maxv, maxv, 31'h7fffffff, 0, 1);
		send_cell(minv, maxv, minv, 31'h7fffffff, 0, 0);
		send_cell(minv, minv, minv, 31'h7fffffff, 0, 0);
		send_cell(maxv, hv, minv, 31'h10000, 1, 1);
		send_cell(hv, unit_z, maxv, 31'h1234, 0, 0);
		start <= 1'b0;
		// hold off until every expected rate has come back
		wait_drained();

		// reduced mode, computed norm gain, beta at its negative extreme
		set_mode(32'h10000, 32'h80000000, 1, 1, 32'hffff0000);
		send_cell(unit_z, hv, hv, 31'h8000, 0, 0);
		send_cell(hv, hv, unit_z, 31'h10000, 0, 0);
		send_cell(maxv, minv, hv, 31'h7fffffff, 0, 0);
		send_cell(zero3, hv, hv, 31'h10000, 0, 1);
		send_random(6, 1);
		wait_drained();

		// reduced mode, fixed gain, no precession, extreme gamma
		set_mode(32'h7fffffff, 32'h7fffffff, 0, 1, 32'h7fffffff);
		send_cell(unit_z, hv, hv, 31'h8000, 0, 0);
		send_cell(hv, maxv, minv, 31'h1, 0, 1);
		send_random(6, 3);
		wait_drained();

		// random phases: sender gaps 15%, then 75%, then none
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 15 : (ph == 1) ? 75 : 0;
			set_mode($urandom_range(0, 1) ? 32'h10000 : $urandom_range(0, 32'h40000),
				$urandom_range(0, 2) == 0 ? $urandom() : 32'($signed($urandom_range(0, 65536)) - 32768),
				$urandom_range(0, 1), 1'b0, $urandom_range(0, 1) ? 32'hffff0000 : 32'h30000);
			send_random(75, 3);
			wait_drained();
			write_reg(REG_REDUCED, 32'd1);
			write_reg(REG_NORM_GAIN, (ph == 1) ? 32'h0 : 32'hffff0000);
			send_random(75, 3);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
